>>> rtl/sha256_pkg.sv
`default_nettype none
package sha256_pkg;

    localparam int unsigned WordW   = 32;
    localparam int unsigned CountW  = 3;
    localparam int unsigned IndexW  = 3;
    localparam int unsigned LenW    = 64;
    localparam int unsigned BlkWords = 16;
    localparam int unsigned Rounds  = 64;

    typedef logic [WordW-1:0] t_word;

    localparam t_word PadMarker = 32'h8000_0000;

    localparam t_word InitHash [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam t_word RoundK [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    // Control from the sequencer to the round unit
    typedef struct packed {
        logic       load;   // copy chain into working vars
        logic       round;  // run one round
        logic       fold;   // add working vars into chain
        logic       init;   // restore initial chain
        logic [5:0] rnd;    // round number
    } t_rnd_ctl;

endpackage
`default_nettype wire

>>> rtl/sha256_if.sv
`default_nettype none
interface sha256_in_if;
    logic                           valid;
    logic                           ready;
    logic [sha256_pkg::WordW-1:0]   data_word;
    logic [sha256_pkg::CountW-1:0]  byte_count;
    logic                           last_item;
    modport source (output valid, data_word, byte_count, last_item, input ready);
    modport sink (input valid, data_word, byte_count, last_item, output ready);
endinterface

interface sha256_out_if;
    logic                           valid;
    logic                           ready;
    logic [sha256_pkg::WordW-1:0]   digest_word;
    logic [sha256_pkg::IndexW-1:0]  word_index;
    logic                           last_word;
    modport source (output valid, digest_word, word_index, last_word, input ready);
    modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface
`default_nettype wire

>>> rtl/sha256_round.sv
`default_nettype none
// Shared round unit: message schedule window, working vars and chain hash.
module sha256_round (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  sha256_pkg::t_rnd_ctl    i_ctl,
    input  wire                     i_wr,      // shift a block word into the window
    input  sha256_pkg::t_word       i_wr_word,
    input  wire  [2:0]              i_rd_idx,
    output sha256_pkg::t_word       o_rd_word
);
    sha256_pkg::t_word r_w [16];
    sha256_pkg::t_word r_v [8];
    sha256_pkg::t_word r_h [8];

    sha256_pkg::t_word a, b, c, d, e, f, g, h;
    sha256_pkg::t_word s0, s1, w_new, w_cur, t1, t2, x, y;

    always_comb begin
        a = r_v[0]; b = r_v[1]; c = r_v[2]; d = r_v[3];
        e = r_v[4]; f = r_v[5]; g = r_v[6]; h = r_v[7];
        x = r_w[1];
        y = r_w[14];
        s0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ (x >> 3);
        s1 = {y[16:0], y[31:17]} ^ {y[18:0], y[31:19]} ^ (y >> 10);
        w_new = r_w[0] + s0 + r_w[9] + s1;
        // first sixteen rounds use the loaded words as they are
        w_cur = r_w[0];
        t1 = h + ({e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]})
               + ((e & f) ^ (~e & g)) + sha256_pkg::RoundK[i_ctl.rnd] + w_cur;
        t2 = ({a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]})
               + ((a & b) ^ (a & c) ^ (b & c));
    end

    // Advance the schedule window: load words, or slide with a new expanded word
    always_ff @(posedge i_clk) begin
        if (i_wr || i_ctl.round) begin
            for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
            r_w[15] <= i_wr ? i_wr_word : w_new;
        end
    end

    // Working vars
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            for (int i = 0; i < 8; i++) r_v[i] <= r_h[i];
        end else if (i_ctl.round) begin
            r_v[7] <= g; r_v[6] <= f; r_v[5] <= e; r_v[4] <= d + t1;
            r_v[3] <= c; r_v[2] <= b; r_v[1] <= a; r_v[0] <= t1 + t2;
        end
    end

    // Chain hash
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.init) begin
            for (int i = 0; i < 8; i++) r_h[i] <= sha256_pkg::InitHash[i];
        end else if (i_ctl.fold) begin
            for (int i = 0; i < 8; i++) r_h[i] <= r_h[i] + r_v[i];
        end
    end

    assign o_rd_word = r_h[i_rd_idx];

    property p_no_overlap;
        @(posedge i_clk) disable iff (!i_rst_n) !(i_ctl.load && i_ctl.round);
    endproperty
    a_no_overlap: assert property (p_no_overlap) else $error("load and round together");

    property p_no_wr_round;
        @(posedge i_clk) disable iff (!i_rst_n) !(i_wr && i_ctl.round);
    endproperty
    a_no_wr_round: assert property (p_no_wr_round) else $error("write during round");

    property p_fold_after_round;
        @(posedge i_clk) disable iff (!i_rst_n) i_ctl.fold |-> $past(i_ctl.round);
    endproperty
    a_fold_after_round: assert property (p_fold_after_round) else $error("fold without round");
endmodule
`default_nettype wire

>>> rtl/sha256_stream_hasher.sv
`default_nettype none
// SHA-256 over a byte stream of big-endian 32-bit words. A word not marked
// last is taken as four bytes; the sixteenth of a block starts a 64-round
// compression (one round per cycle on a single shared round unit, plus load
// and fold) during which the input is not ready. A last word adds the
// padding one word per cycle, runs one or two compressions, then offers the
// eight digest words, index 0 first, the eighth marked last.
module sha256_stream_hasher (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    sha256_in_if.sink           i_in,
    sha256_out_if.source        o_out
);
    localparam logic [2:0] S_IN   = 3'd0;
    localparam logic [2:0] S_PAD  = 3'd1;
    localparam logic [2:0] S_LOAD = 3'd2;
    localparam logic [2:0] S_RND  = 3'd3;
    localparam logic [2:0] S_FOLD = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0]  r_state, n_state;
    logic [3:0]  r_fill, n_fill;
    logic [63:0] r_bits, n_bits;
    logic [5:0]  r_rnd, n_rnd;
    logic        r_fin, n_fin;   // message ended; padding phase
    logic [2:0]  r_oidx, n_oidx;
    logic        r_mark, n_mark; // full last word: marker word still to come
    logic        r_len, n_len;   // length high word placed in this block

    sha256_pkg::t_rnd_ctl ctl;
    logic                 wr;
    sha256_pkg::t_word    wr_word, rd_word, last_word_v;
    logic [2:0]           cnt;
    logic                 acc;

    sha256_round u_round (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (ctl),
        .i_wr     (wr),
        .i_wr_word(wr_word),
        .i_rd_idx (r_oidx),
        .o_rd_word(rd_word)
    );

    assign i_in.ready = (r_state == S_IN);
    assign acc = i_in.valid && i_in.ready;
    assign cnt = (i_in.byte_count > 3'd4) ? 3'd4 : i_in.byte_count;

    // Mask partial word and place the marker
    always_comb begin
        unique case (cnt)
            3'd0:    last_word_v = 32'h8000_0000;
            3'd1:    last_word_v = {i_in.data_word[31:24], 24'h80_0000};
            3'd2:    last_word_v = {i_in.data_word[31:16], 16'h8000};
            3'd3:    last_word_v = {i_in.data_word[31:8], 8'h80};
            default: last_word_v = i_in.data_word;
        endcase
    end

    assign o_out.valid       = (r_state == S_OUT);
    assign o_out.digest_word = rd_word;
    assign o_out.word_index  = r_oidx;
    assign o_out.last_word   = (r_oidx == 3'd7);

    // Sequencer
    always_comb begin
        n_state = r_state; n_fill = r_fill; n_bits = r_bits; n_rnd = r_rnd;
        n_fin = r_fin; n_oidx = r_oidx; n_mark = r_mark; n_len = r_len;
        wr = 1'b0; wr_word = i_in.data_word;
        ctl = '0; ctl.rnd = r_rnd;
        unique case (r_state)
            S_IN: begin
                if (acc) begin
                    wr = 1'b1;
                    n_fill = r_fill + 4'd1;
                    if (!i_in.last_item) begin
                        n_bits = r_bits + 64'd32;
                        if (r_fill == 4'd15) n_state = S_LOAD;
                    end else begin
                        n_bits = r_bits + {58'd0, cnt, 3'd0};
                        n_fin = 1'b1;
                        wr_word = last_word_v;
                        // a full last word still needs its marker word
                        n_mark = (cnt == 3'd4);
                        n_len = 1'b0;
                        n_state = (r_fill == 4'd15) ? S_LOAD : S_PAD;
                    end
                end
            end
            S_PAD: begin
                wr = 1'b1;
                n_fill = r_fill + 4'd1;
                if (r_mark) begin
                    wr_word = sha256_pkg::PadMarker;
                    n_mark = 1'b0;
                end else if (r_fill == 4'd14) begin
                    wr_word = r_bits[63:32];
                    n_len = 1'b1;
                end else if (r_fill == 4'd15 && r_len) begin
                    wr_word = r_bits[31:0];
                end else begin
                    wr_word = '0;
                end
                if (r_fill == 4'd15) n_state = S_LOAD;
            end
            S_LOAD: begin
                ctl.load = 1'b1; n_rnd = '0; n_state = S_RND;
            end
            S_RND: begin
                ctl.round = 1'b1; n_rnd = r_rnd + 6'd1;
                if (r_rnd == 6'd63) n_state = S_FOLD;
            end
            S_FOLD: begin
                ctl.fold = 1'b1; n_fill = '0;
                if (!r_fin) n_state = S_IN;
                else if (r_len) n_state = S_OUT;
                else n_state = S_PAD;
                n_oidx = '0;
            end
            S_OUT: begin
                if (o_out.ready) begin
                    n_oidx = r_oidx + 3'd1;
                    if (r_oidx == 3'd7) begin
                        ctl.init = 1'b1; n_state = S_IN; n_fin = 1'b0;
                        n_bits = '0; n_fill = '0; n_len = 1'b0;
                    end
                end
            end
            default: n_state = S_IN;
        endcase
    end

    // Hold the state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IN; r_fill <= '0; r_bits <= '0; r_rnd <= '0;
            r_fin <= 1'b0; r_oidx <= '0; r_mark <= 1'b0; r_len <= 1'b0;
        end else begin
            r_state <= n_state; r_fill <= n_fill; r_bits <= n_bits; r_rnd <= n_rnd;
            r_fin <= n_fin; r_oidx <= n_oidx; r_mark <= n_mark; r_len <= n_len;
        end
    end

    property p_ready_idle;
        @(posedge i_clk) disable iff (!i_rst_n) o_out.valid |-> !i_in.ready;
    endproperty
    a_ready_idle: assert property (p_ready_idle) else $error("input taken during output");

    property p_out_from_fold;
        @(posedge i_clk) disable iff (!i_rst_n) $rose(o_out.valid) |-> $past(r_state == S_FOLD);
    endproperty
    a_out_from_fold: assert property (p_out_from_fold) else $error("digest without compression");

    property p_idx_start;
        @(posedge i_clk) disable iff (!i_rst_n) $rose(o_out.valid) |-> r_oidx == 3'd0;
    endproperty
    a_idx_start: assert property (p_idx_start) else $error("digest index not at zero");
endmodule
`default_nettype wire

>>> sim/tb_sha256_stream_hasher.sv
`timescale 1ns / 1ps
`default_nettype none
module tb_sha256_stream_hasher;

    typedef struct packed {
        logic [31:0] data;
        logic [2:0]  count;
        logic        last;
    } t_in_word;

    typedef struct packed {
        logic [31:0] digest;
        logic [2:0]  index;
        logic        last;
    } t_out_word;

    localparam int unsigned MaxCycles = 100000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    sha256_in_if  in_ch ();
    sha256_out_if out_ch ();

    sha256_stream_hasher uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source)
    );

    always #5 i_clk = ~i_clk;

    // Hash state of the predictor
    sha256_pkg::t_word hash_st [8];
    sha256_pkg::t_word blk_buf [16];
    int unsigned       blk_fill;
    logic [63:0]       msg_bits;

    t_in_word    pending_words[$];
    t_out_word   expected_digests[$];
    int unsigned errors = 0;
    int unsigned digests_seen = 0;
    int unsigned messages_sent = 0;
    int unsigned cycle_cnt = 0;
    bit          hold_sink = 1'b0;

    function automatic sha256_pkg::t_word rotr(sha256_pkg::t_word x, int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    task automatic hash_block();
        sha256_pkg::t_word w [64];
        sha256_pkg::t_word v [8];
        sha256_pkg::t_word s0, s1, t1, t2;
        for (int i = 0; i < 16; i++) w[i] = blk_buf[i];
        for (int i = 16; i < 64; i++) begin
            s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
            s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
            w[i] = w[i-16] + s0 + w[i-7] + s1;
        end
        for (int i = 0; i < 8; i++) v[i] = hash_st[i];
        for (int i = 0; i < 64; i++) begin
            t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
                 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha256_pkg::RoundK[i] + w[i];
            t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
                 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) hash_st[i] += v[i];
    endtask

    task automatic buffer_word(sha256_pkg::t_word word);
        blk_buf[blk_fill] = word;
        blk_fill++;
        if (blk_fill == 16) begin
            hash_block();
            blk_fill = 0;
        end
    endtask

    task automatic restart_hash();
        for (int i = 0; i < 8; i++) hash_st[i] = sha256_pkg::InitHash[i];
        blk_fill = 0;
        msg_bits = '0;
    endtask

    // Append to the queues
    task automatic add_pending(t_in_word iw);
        pending_words = {pending_words, iw};
    endtask

    task automatic add_expected(t_out_word ow);
        expected_digests = {expected_digests, ow};
    endtask

    // Advance the predictor by one accepted word
    task automatic predict_digest(t_in_word iw);
        int unsigned       n;
        sha256_pkg::t_word mask;
        t_out_word         ow;
        if (!iw.last) begin
            msg_bits += 64'd32;
            buffer_word(iw.data);
            return;
        end
        n = (iw.count > 4) ? 4 : iw.count;
        msg_bits += 64'(n * 8);
        if (n == 4) begin
            buffer_word(iw.data);
            buffer_word(sha256_pkg::PadMarker);
        end else begin
            mask = (n == 0) ? '0 : (32'hFFFF_FFFF << (32 - 8 * n));
            buffer_word((iw.data & mask) | (32'h80 << (24 - 8 * n)));
        end
        if (blk_fill > 14)
            while (blk_fill != 0) buffer_word('0);
        while (blk_fill < 14) buffer_word('0);
        buffer_word(msg_bits[63:32]);
        buffer_word(msg_bits[31:0]);
        for (int i = 0; i < 8; i++) begin
            ow.digest = hash_st[i];
            ow.index  = 3'(i);
            ow.last   = (i == 7);
            add_expected(ow);
        end
        restart_hash();
    endtask

    task automatic report_mismatch(string what, t_out_word got, t_out_word want);
        $display("ERROR %0s: got %h/%0d/%0b want %h/%0d/%0b", what,
                 got.digest, got.index, got.last, want.digest, want.index, want.last);
        errors++;
    endtask

    function automatic t_in_word make_word(logic [31:0] d, logic [2:0] c, logic l);
        t_in_word iw;
        iw.data = d; iw.count = c; iw.last = l;
        return iw;
    endfunction

    // Queue one message of full words closed by a last word
    task automatic queue_message(int unsigned full_words, logic [2:0] tail_cnt);
        for (int i = 0; i < full_words; i++)
            add_pending(make_word($urandom, 3'($urandom_range(0, 7)), 1'b0));
        add_pending(make_word($urandom, tail_cnt, 1'b1));
    endtask

    // Driver: offer one word at a time with random gaps
    int unsigned drv_gap = 0;
    t_in_word    drv_cur;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready) begin
                predict_digest(drv_cur);
                drv_gap = $urandom_range(0, 3) == 0 ? $urandom_range(0, 16) : 0;
            end
            if (!(in_ch.valid && !in_ch.ready)) begin
                if (drv_gap > 0) begin
                    drv_gap--;
                    in_ch.valid <= 1'b0;
                end else if (pending_words.size() > 0) begin
                    drv_cur = pending_words.pop_front();
                    in_ch.valid      <= 1'b1;
                    in_ch.data_word  <= drv_cur.data;
                    in_ch.byte_count <= drv_cur.count;
                    in_ch.last_item  <= drv_cur.last;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end else begin
            in_ch.valid      <= 1'b0;
            in_ch.data_word  <= '0;
            in_ch.byte_count <= '0;
            in_ch.last_item  <= 1'b0;
        end
    end

    // Monitor: check each digest word against the oldest expectation
    int unsigned mon_gap = 0;
    t_out_word   got, want;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                got.digest = out_ch.digest_word;
                got.index  = out_ch.word_index;
                got.last   = out_ch.last_word;
                digests_seen++;
                if (expected_digests.size() == 0) begin
                    report_mismatch("unexpected word", got, got);
                end else begin
                    want = expected_digests.pop_front();
                    if (got.digest !== want.digest) report_mismatch("digest", got, want);
                    if (got.index !== want.index) report_mismatch("index", got, want);
                    if (got.last !== want.last) report_mismatch("last flag", got, want);
                end
                mon_gap = $urandom_range(0, 3) == 0 ? $urandom_range(0, 16) : 0;
            end
            if (hold_sink) begin
                out_ch.ready <= 1'b0;
            end else if (mon_gap > 0) begin
                mon_gap--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end else begin
            out_ch.ready <= 1'b0;
        end
    end

    // Hold off the sink for a long stretch while messages keep coming
    initial begin
        wait (messages_sent > 0 && i_rst_n);
        repeat (300) @(posedge i_clk);
        hold_sink = 1'b1;
        repeat (2000) @(posedge i_clk);
        hold_sink = 1'b0;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > MaxCycles) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial begin
        restart_hash();
        // Directed: empty message, every tail count, counts above four,
        // ignored bytes past the count, two-block padding, full block
        queue_message(0, 3'd0);
        for (int c = 0; c <= 7; c++) queue_message(0, 3'(c));
        add_pending(make_word(32'hFFFF_FFFF, 3'd7, 1'b0));
        add_pending(make_word(32'h0000_0000, 3'd1, 1'b0));
        add_pending(make_word(32'hFFFF_FFFF, 3'd3, 1'b1));
        queue_message(13, 3'd4);
        queue_message(16, 3'd0);
        messages_sent = 12;
        // Random messages, mostly short
        while (messages_sent < 22) begin
            queue_message(($urandom_range(0, 7) == 0) ? $urandom_range(14, 33)
                                                      : $urandom_range(0, 4),
                          3'($urandom_range(0, 7)));
            messages_sent++;
        end
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (pending_words.size() == 0 && !in_ch.valid);
        wait (expected_digests.size() == 0);
        repeat (200) @(posedge i_clk);
        $display("Covered %0d messages, %0d digest words checked.",
                 messages_sent, digests_seen);
        if (errors == 0 && expected_digests.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end
endmodule
`default_nettype wire

>>> files.f
rtl/sha256_pkg.sv
rtl/sha256_if.sv
rtl/sha256_round.sv
rtl/sha256_stream_hasher.sv
sim/tb_sha256_stream_hasher.sv
